### src/sst_pkg.sv
// shared types and constants of the syn scan port tracker
package sst_pkg;

    // port table size and index width
    localparam int PORT_COUNT = 65536;
    localparam int IDX_W      = $clog2(PORT_COUNT);
    localparam logic [16:0] PORT_LIMIT = 17'(PORT_COUNT);

    // command queue depth between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // packet layout
    localparam logic [15:0] IP_PROTO_BYTE = 16'd9;
    localparam logic [15:0] IP_SRC_BYTE   = 16'd12;
    localparam logic [15:0] IP_DST_BYTE   = 16'd16;
    localparam logic [15:0] IP_MIN_HDR    = 16'd20;
    localparam logic [3:0]  IP_MIN_WORDS  = 4'd5;
    localparam logic [6:0]  TCP_HDR_SPAN  = 7'd14;
    localparam logic [3:0]  TCP_SPORT_END = 4'd2;
    localparam logic [3:0]  TCP_DPORT_END = 4'd4;
    localparam logic [3:0]  TCP_FLAG_OFF  = 4'd13;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    // port table entry codes
    typedef enum logic [2:0] {
        ST_UNMARKED = 3'd0,
        ST_PENDING  = 3'd1,
        ST_PROBED   = 3'd2,
        ST_OPEN     = 3'd3,
        ST_CLOSED   = 3'd4
    } port_state_t;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_PROBE  = 2'd1,
        OUT_OPEN   = 2'd2,
        OUT_CLOSED = 2'd3
    } outcome_t;

    // command handed from front to back
    typedef enum logic [2:0] {
        CMD_MARK  = 3'd0,
        CMD_NOP   = 3'd1,
        CMD_PROBE = 3'd2,
        CMD_OPEN  = 3'd3,
        CMD_CLOSE = 3'd4
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] port;
    } cmd_t;

    // back status and result toward the top level
    typedef struct packed {
        logic        clearing;
        logic        done;
        outcome_t    outcome;
        logic [15:0] port;
        logic [15:0] marked;
        logic [15:0] probed;
        logic [15:0] opened;
        logic [15:0] closed;
    } back_res_t;

endpackage

### src/syn_scan_port_tracker.sv
// top level of the syn scan port tracker
//
//  channel   handshake               payload
//  input     start, busy             operation, port_to_mark, pkt_byte, last_byte
//  config    cfg_valid, cfg_ready    cfg_data (target address)
//  result    done (one-cycle strobe) outcome, port, *_count
//
// The front takes one request per cycle while busy is low; packet bytes are
// parsed as they arrive. Each mark and each packet end takes the back through
// a table read and an update; a four-entry queue absorbs bursts and busy rises
// when it is full or while the port table is swept.
// A packet's result is strobed from the done register after the update step.
// After reset the port table is swept with busy high.
// Results are strobed once and cannot be held off by the receiver.
module syn_scan_port_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] port_to_mark,
    input  logic [7:0]  pkt_byte,
    input  logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [1:0]  outcome,
    output logic [15:0] port,
    output logic [15:0] marked_count,
    output logic [15:0] probed_count,
    output logic [15:0] open_count,
    output logic [15:0] closed_count,
    output logic [15:0] filtered_count
);
    import sst_pkg::*;

    logic [31:0] target_reg;
    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    cmd_t        head;
    logic        empty;
    logic        full;
    logic        pop;
    back_res_t   res;

    // target address register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg_valid && cfg_ready)
            target_reg <= cfg_data;
    end

    // request acceptance
    assign busy   = res.clearing || full;
    assign accept = start && !busy;

    sst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .port_to_mark (port_to_mark),
        .pkt_byte     (pkt_byte),
        .last_byte    (last_byte),
        .target_addr  (target_reg),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    sst_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    sst_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

    // result ports
    assign done           = res.done;
    assign outcome        = res.outcome;
    assign port           = res.port;
    assign marked_count   = res.marked;
    assign probed_count   = res.probed;
    assign open_count     = res.opened;
    assign closed_count   = res.closed;
    assign filtered_count = res.marked - res.opened - res.closed;

endmodule

### src/sst_front.sv
// front part: packet header parsing and request classification
module sst_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         operation,
    input  logic [15:0]  port_to_mark,
    input  logic [7:0]   pkt_byte,
    input  logic         last_byte,
    input  logic [31:0]  target_addr,
    output logic         push,
    output sst_pkg::cmd_t push_cmd
);
    import sst_pkg::*;

    logic [15:0] idx_reg, idx_next;
    logic [3:0]  hw_reg, hw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [7:0]  flags_reg, flags_next;
    logic        cap_reg, cap_next;

    // parse one byte and classify at packet end, or pass on a mark request
    always_comb
    begin
        logic [5:0]  hl;
        logic [6:0]  tcp_end;
        logic [3:0]  off;
        logic        got_flags;

        idx_next   = idx_reg;
        hw_next    = hw_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        flags_next = flags_reg;
        cap_next   = cap_reg;
        push       = 1'b0;
        push_cmd   = '{op: CMD_NOP, port: 16'd0};
        hl         = '0;
        tcp_end    = '0;
        off        = '0;
        got_flags  = 1'b0;

        if (accept && operation)
        begin
            // ip header fields
            if (idx_reg == 16'd0)
                hw_next = pkt_byte[3:0];
            else if (idx_reg == IP_PROTO_BYTE)
                proto_next = pkt_byte;
            else if (idx_reg >= IP_SRC_BYTE && idx_reg < IP_DST_BYTE)
                src_next = {src_reg[23:0], pkt_byte};
            else if (idx_reg >= IP_DST_BYTE && idx_reg < IP_MIN_HDR)
                dst_next = {dst_reg[23:0], pkt_byte};

            // tcp ports and flags after the ip header
            hl      = {hw_next, 2'b00};
            tcp_end = {1'b0, hl} + TCP_HDR_SPAN;
            if (hw_next >= IP_MIN_WORDS && idx_reg >= IP_MIN_HDR
                && idx_reg >= {10'd0, hl} && idx_reg < {9'd0, tcp_end})
            begin
                off = 4'(idx_reg[6:0] - {1'b0, hl});
                if (off < TCP_SPORT_END)
                    sport_next = {sport_reg[7:0], pkt_byte};
                else if (off < TCP_DPORT_END)
                    dport_next = {dport_reg[7:0], pkt_byte};
                else if (off == TCP_FLAG_OFF)
                begin
                    flags_next = pkt_byte;
                    cap_next   = 1'b1;
                end
            end

            if (idx_reg != 16'hFFFF)
                idx_next = idx_reg + 16'd1;

            // packet end: decide what the back has to do
            if (last_byte)
            begin
                push      = 1'b1;
                got_flags = cap_next;
                if (got_flags && hw_next >= IP_MIN_WORDS && proto_next == PROTO_TCP)
                begin
                    if (dst_next == target_addr)
                    begin
                        if (flags_next[FLAG_SYN] && {1'b0, dport_next} < PORT_LIMIT)
                            push_cmd = '{op: CMD_PROBE, port: dport_next};
                    end
                    else if (src_next == target_addr)
                    begin
                        if (flags_next[FLAG_ACK] && {1'b0, sport_next} < PORT_LIMIT)
                        begin
                            if (flags_next[FLAG_SYN])
                                push_cmd = '{op: CMD_OPEN, port: sport_next};
                            else if (flags_next[FLAG_RST])
                                push_cmd = '{op: CMD_CLOSE, port: sport_next};
                        end
                    end
                end
                idx_next = 16'd0;
                cap_next = 1'b0;
            end
        end
        else if (accept)
        begin
            // mark request for a nonzero port inside the table
            if (port_to_mark != 16'd0 && {1'b0, port_to_mark} < PORT_LIMIT)
            begin
                push     = 1'b1;
                push_cmd = '{op: CMD_MARK, port: port_to_mark};
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            flags_reg <= '0;
            cap_reg   <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            hw_reg    <= hw_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            flags_reg <= flags_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

### src/sst_fifo.sv
// short command queue between front and back
module sst_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sst_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sst_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import sst_pkg::*;

    cmd_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head  = slot_reg[rptr_reg];

    // pointer and fill count
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_cmd;
    end

endmodule

### src/sst_back.sv
// back part: port table, counters and result generation
module sst_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sst_pkg::cmd_t     head,
    input  logic              empty,
    output logic              pop,
    output sst_pkg::back_res_t res
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [15:0]       marked_reg, marked_next;
    logic [15:0]       probed_reg, probed_next;
    logic [15:0]       open_reg, open_next;
    logic [15:0]       closed_reg, closed_next;
    logic              done_reg, done_next;
    outcome_t          outcome_reg, outcome_next;
    logic [15:0]       port_reg, port_next;

    port_state_t       port_mem [PORT_COUNT];
    port_state_t       rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    port_state_t       mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;

    assign mem_raddr = head.port[IDX_W-1:0];

    // sequencer: clear sweep, table read, update
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        clr_next     = clr_reg;
        marked_next  = marked_reg;
        probed_next  = probed_reg;
        open_next    = open_reg;
        closed_next  = closed_reg;
        done_next    = 1'b0;
        outcome_next = OUT_NONE;
        port_next    = 16'd0;
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cmd_reg.port[IDX_W-1:0];
        mem_wdata    = ST_UNMARKED;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(PORT_COUNT-1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = (cmd_reg.op != CMD_MARK);
                case (cmd_reg.op)
                    CMD_MARK:
                    begin
                        if (rd_data_reg == ST_UNMARKED)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = ST_PENDING;
                            marked_next = marked_reg + 16'd1;
                        end
                    end
                    CMD_PROBE:
                    begin
                        if (rd_data_reg == ST_PENDING)
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = ST_PROBED;
                            probed_next  = probed_reg + 16'd1;
                            outcome_next = OUT_PROBE;
                            port_next    = cmd_reg.port;
                        end
                    end
                    CMD_OPEN:
                    begin
                        if (rd_data_reg == ST_PENDING || rd_data_reg == ST_PROBED)
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = ST_OPEN;
                            open_next    = open_reg + 16'd1;
                            outcome_next = OUT_OPEN;
                            port_next    = cmd_reg.port;
                        end
                    end
                    CMD_CLOSE:
                    begin
                        if (rd_data_reg == ST_PENDING || rd_data_reg == ST_PROBED)
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = ST_CLOSED;
                            closed_next  = closed_reg + 16'd1;
                            outcome_next = OUT_CLOSED;
                            port_next    = cmd_reg.port;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cmd_reg     <= '{op: CMD_NOP, port: 16'd0};
            clr_reg     <= '0;
            marked_reg  <= '0;
            probed_reg  <= '0;
            open_reg    <= '0;
            closed_reg  <= '0;
            done_reg    <= 1'b0;
            outcome_reg <= OUT_NONE;
            port_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            clr_reg     <= clr_next;
            marked_reg  <= marked_next;
            probed_reg  <= probed_next;
            open_reg    <= open_next;
            closed_reg  <= closed_next;
            done_reg    <= done_next;
            outcome_reg <= outcome_next;
            port_reg    <= port_next;
        end
    end

    // port table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            port_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= port_mem[mem_raddr];
    end

    // counters only move in the update step, so they hold while done is shown
    assign res = '{
        clearing: (state_reg == S_CLEAR),
        done:     done_reg,
        outcome:  outcome_reg,
        port:     port_reg,
        marked:   marked_reg,
        probed:   probed_reg,
        opened:   open_reg,
        closed:   closed_reg
    };

endmodule

### dv/tb.sv
// testbench for the syn scan port tracker: random and directed traffic checked against a predictor
module tb;
    import sst_pkg::*;

    // request kinds on the operation port
    localparam logic OP_MARK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // tcp flag masks
    localparam logic [7:0] F_SYN = 8'(1 << FLAG_SYN);
    localparam logic [7:0] F_RST = 8'(1 << FLAG_RST);
    localparam logic [7:0] F_ACK = 8'(1 << FLAG_ACK);

    localparam int POOL_N = 32;

    typedef struct {
        logic        op;
        logic [15:0] mport;
        logic [7:0]  pbyte;
        logic        lastb;
    } scan_req_t;

    typedef struct {
        outcome_t    oc;
        logic [15:0] port;
        logic [15:0] marked;
        logic [15:0] probed;
        logic [15:0] opened;
        logic [15:0] closed;
        logic [15:0] filtered;
    } scan_res_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = 1'b0;
    logic [15:0] port_to_mark = '0;
    logic [7:0]  pkt_byte = '0;
    logic        last_byte = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        done;
    logic [1:0]  outcome;
    logic [15:0] port;
    logic [15:0] marked_count;
    logic [15:0] probed_count;
    logic [15:0] open_count;
    logic [15:0] closed_count;
    logic [15:0] filtered_count;

    syn_scan_port_tracker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .port_to_mark   (port_to_mark),
        .pkt_byte       (pkt_byte),
        .last_byte      (last_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .outcome        (outcome),
        .port           (port),
        .marked_count   (marked_count),
        .probed_count   (probed_count),
        .open_count     (open_count),
        .closed_count   (closed_count),
        .filtered_count (filtered_count)
    );

    // requests waiting to be sent and reports still owed by the block
    scan_req_t   req_backlog[$];
    scan_res_t   due_reports[$];
    scan_req_t   cur_req;
    int          send_idle_pct = 0;
    int          err_count = 0;
    logic [15:0] port_pool [POOL_N];

    // shadow of the tracker state
    port_state_t tbl [PORT_COUNT];
    logic [31:0] tgt_addr = '0;
    logic [15:0] bidx = '0;
    logic [3:0]  hwords = '0;
    logic [7:0]  proto = '0;
    logic [31:0] saddr = '0;
    logic [31:0] daddr = '0;
    logic [15:0] sport = '0;
    logic [15:0] dport = '0;
    logic [7:0]  flags = '0;
    bit          fcap = 1'b0;
    logic [15:0] n_marked = '0;
    logic [15:0] n_probed = '0;
    logic [15:0] n_open = '0;
    logic [15:0] n_closed = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // header and tcp field capture for one packet byte
    function automatic void take_byte(logic [7:0] b);
        int i;
        int hl;
        int off;
        i = bidx;
        if (i == 0) hwords = b[3:0];
        else if (i == 9) proto = b;
        else if (i >= 12 && i < 16) saddr = {saddr[23:0], b};
        else if (i >= 16 && i < 20) daddr = {daddr[23:0], b};
        if (hwords >= IP_MIN_WORDS && i >= 20)
        begin
            hl = hwords * 4;
            if (i >= hl && i < hl + 14)
            begin
                off = i - hl;
                if (off < 2) sport = {sport[7:0], b};
                else if (off < 4) dport = {dport[7:0], b};
                else if (off == 13)
                begin
                    flags = b;
                    fcap = 1'b1;
                end
            end
        end
        if (bidx != 16'hFFFF) bidx++;
    endfunction

    // advance the shadow state by one accepted request, queue the report it owes
    function automatic void track_request(scan_req_t r);
        scan_res_t res;
        if (r.op == OP_MARK)
        begin
            if (r.mport != 0 && r.mport < PORT_COUNT && tbl[r.mport] == ST_UNMARKED)
            begin
                tbl[r.mport] = ST_PENDING;
                n_marked++;
            end
            return;
        end
        take_byte(r.pbyte);
        if (!r.lastb) return;
        res.oc = OUT_NONE;
        res.port = '0;
        if (fcap && hwords >= IP_MIN_WORDS && proto == PROTO_TCP)
        begin
            if (daddr == tgt_addr)
            begin
                if (flags[FLAG_SYN] && dport < PORT_COUNT && tbl[dport] == ST_PENDING)
                begin
                    tbl[dport] = ST_PROBED;
                    n_probed++;
                    res.oc = OUT_PROBE;
                    res.port = dport;
                end
            end
            else if (saddr == tgt_addr)
            begin
                if (sport < PORT_COUNT && flags[FLAG_ACK] &&
                    (tbl[sport] == ST_PENDING || tbl[sport] == ST_PROBED))
                begin
                    if (flags[FLAG_SYN])
                    begin
                        tbl[sport] = ST_OPEN;
                        n_open++;
                        res.oc = OUT_OPEN;
                        res.port = sport;
                    end
                    else if (flags[FLAG_RST])
                    begin
                        tbl[sport] = ST_CLOSED;
                        n_closed++;
                        res.oc = OUT_CLOSED;
                        res.port = sport;
                    end
                end
            end
        end
        bidx = '0;
        fcap = 1'b0;
        res.marked = n_marked;
        res.probed = n_probed;
        res.opened = n_open;
        res.closed = n_closed;
        res.filtered = n_marked - n_open - n_closed;
        due_reports.push_back(res);
    endfunction

    function automatic void report(string msg);
        err_count++;
        if (err_count <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) report($sformatf("%s expected %0h got %0h", name, e, a));
    endfunction

    function automatic void push_mark(logic [15:0] p);
        scan_req_t r;
        r.op = OP_MARK;
        r.mport = p;
        r.pbyte = 8'($urandom);
        r.lastb = 1'($urandom);
        req_backlog.push_back(r);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic lastb);
        scan_req_t r;
        r.op = OP_BYTE;
        r.mport = 16'($urandom);
        r.pbyte = b;
        r.lastb = lastb;
        req_backlog.push_back(r);
    endfunction

    function automatic logic [31:0] other_addr();
        logic [31:0] a;
        a = $urandom;
        if (a == tgt_addr) a = ~a;
        return a;
    endfunction

    // one ipv4 packet with a tcp header behind it; cut > 0 truncates it
    task automatic add_packet(input logic [3:0] ihl, input logic [7:0] proto_b,
                              input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input logic [7:0] flg, input int cut, input int extra,
                              input bit mix);
        logic [7:0] pkt[];
        int tcp_at;
        int len;
        tcp_at = (ihl >= IP_MIN_WORDS) ? int'(ihl) * 4 : 20;
        len = tcp_at + 20 + extra;
        pkt = new[len];
        if (cut > 0 && cut < len) len = cut;
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        pkt[0][3:0] = ihl;
        pkt[9] = proto_b;
        for (int k = 0; k < 4; k++)
        begin
            pkt[12 + k] = src[31 - 8 * k -: 8];
            pkt[16 + k] = dst[31 - 8 * k -: 8];
        end
        pkt[tcp_at]      = sp[15:8];
        pkt[tcp_at + 1]  = sp[7:0];
        pkt[tcp_at + 2]  = dp[15:8];
        pkt[tcp_at + 3]  = dp[7:0];
        pkt[tcp_at + 13] = flg;
        // marks may fall between bytes of the packet
        for (int k = 0; k < len; k++)
        begin
            if (mix && $urandom_range(24) == 0)
                push_mark(port_pool[$urandom_range(POOL_N - 1)]);
            push_byte(pkt[k], k == len - 1);
        end
    endtask

    task automatic refresh_pool();
        port_pool[0] = 16'd1;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = 16'h8000;
        port_pool[3] = 16'h7FFF;
        for (int k = 4; k < POOL_N; k++) port_pool[k] = 16'($urandom_range(65535, 1));
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (req_backlog.size() != 0 || start || due_reports.size() != 0);
    endtask

    task automatic write_target(input logic [31:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tgt_addr = v;
    endtask

    // settle, reprogram the target and pick the sender idle rate
    task automatic begin_phase(input logic [31:0] v, input int idle_pct);
        wait_drained();
        repeat (20) @(negedge clk);
        write_target(v);
        @(negedge clk);
        send_idle_pct = idle_pct;
        refresh_pool();
    endtask

    // mostly scan conversations on a small port pool, some broken packets and noise
    task automatic make_random_traffic(input int n_req, input int n_pkt);
        int r;
        int sel;
        int pkts;
        int extra;
        int n;
        bit mix;
        logic [15:0] p;
        logic [15:0] q;
        logic [7:0] flg;
        logic [7:0] pr;
        logic [3:0] ihl;
        pkts = 0;
        while (req_backlog.size() < n_req || pkts < n_pkt)
        begin
            r = $urandom_range(99);
            p = port_pool[$urandom_range(POOL_N - 1)];
            q = port_pool[$urandom_range(POOL_N - 1)];
            ihl = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 6)) : IP_MIN_WORDS;
            extra = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : 0;
            mix = ($urandom_range(7) == 0);
            if (r < 20)
            begin
                push_mark(p);
            end
            else if (r < 45)
            begin
                // probe toward the target
                flg = 8'($urandom);
                if ($urandom_range(9) != 0) flg = flg | F_SYN;
                else flg = flg & ~F_SYN;
                add_packet(ihl, PROTO_TCP, other_addr(), tgt_addr, 16'($urandom), p, flg,
                           0, extra, mix);
                pkts++;
            end
            else if (r < 70)
            begin
                // reply from the target
                sel = $urandom_range(3);
                case (sel)
                    0: flg = F_SYN | F_ACK;
                    1: flg = F_RST | F_ACK;
                    2: flg = F_ACK;
                    default: flg = 8'($urandom);
                endcase
                add_packet(ihl, PROTO_TCP, tgt_addr, other_addr(), p, 16'($urandom), flg,
                           0, extra, mix);
                pkts++;
            end
            else if (r < 78)
            begin
                // target on both sides
                flg = 8'($urandom) | F_ACK;
                add_packet(ihl, PROTO_TCP, tgt_addr, tgt_addr, q, p, flg, 0, extra, mix);
                pkts++;
            end
            else if (r < 86)
            begin
                // well formed probe broken in one place
                sel = $urandom_range(2);
                pr = PROTO_TCP;
                if (sel == 0)
                begin
                    pr = 8'($urandom);
                    if (pr == PROTO_TCP) pr = pr ^ 8'h01;
                end
                else if (sel == 1)
                begin
                    ihl = 4'($urandom_range(4));
                end
                add_packet(ihl, pr, other_addr(), tgt_addr, 16'($urandom), p, F_SYN,
                           (sel == 2) ? $urandom_range(int'(ihl) * 4 + 13, 1) : 0,
                           extra, mix);
                pkts++;
            end
            else if (r < 94)
            begin
                // raw noise packet
                n = $urandom_range(70, 1);
                for (int k = 0; k < n; k++) push_byte(8'($urandom), k == n - 1);
                pkts++;
            end
            else
            begin
                push_mark(($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
            end
        end
    endtask

    // driver: one request per accepted handshake
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy) track_request(cur_req);
            if (!start || !busy)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req = req_backlog.pop_front();
                    start <= 1'b1;
                    operation <= cur_req.op;
                    port_to_mark <= cur_req.mport;
                    pkt_byte <= cur_req.pbyte;
                    last_byte <= cur_req.lastb;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: reports are sampled mid-cycle while the strobe is up
    always @(negedge clk)
    begin : mon
        scan_res_t e;
        if (rst_n && done)
        begin
            if (due_reports.size() == 0)
            begin
                report($sformatf("result with nothing expected, outcome %0d port %0d",
                                 outcome, port));
            end
            else
            begin
                e = due_reports.pop_front();
                check_field("outcome", e.oc, outcome);
                check_field("port", e.port, port);
                check_field("marked_count", e.marked, marked_count);
                check_field("probed_count", e.probed, probed_count);
                check_field("open_count", e.opened, open_count);
                check_field("closed_count", e.closed, closed_count);
                check_field("filtered_count", e.filtered, filtered_count);
            end
        end
    end

    initial
    begin : main_seq
        foreach (tbl[i]) tbl[i] = ST_UNMARKED;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases
        begin_phase(32'hC0A8_0A01, 38);
        push_mark(16'd0);
        push_mark(16'd1);
        push_mark(16'hFFFF);
        push_mark(16'd1);
        push_mark(16'd80);
        push_mark(16'd22);
        push_mark(16'd8080);
        add_packet(IP_MIN_WORDS, PROTO_TCP, other_addr(), tgt_addr, 16'hABCD, 16'd1, F_SYN,
                   0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, other_addr(), tgt_addr, 16'hABCD, 16'd1, F_SYN,
                   0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, other_addr(), 16'd1, 16'h1234,
                   F_SYN | F_ACK, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, other_addr(), 16'hFFFF, 16'h1234,
                   F_RST | F_ACK, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, other_addr(), 16'd80, 16'h1234,
                   F_ACK, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, other_addr(), 16'd443, 16'h1234,
                   F_SYN | F_ACK, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, other_addr(), 16'd1, 16'h1234,
                   F_RST | F_ACK, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, 8'd17, other_addr(), tgt_addr, 16'h4321, 16'd80, F_SYN,
                   0, 0, 1'b0);
        add_packet(4'd4, PROTO_TCP, other_addr(), tgt_addr, 16'h4321, 16'd80, F_SYN,
                   0, 0, 1'b0);
        add_packet(4'd15, PROTO_TCP, other_addr(), tgt_addr, 16'h4321, 16'd80, F_SYN,
                   0, 3, 1'b1);
        add_packet(IP_MIN_WORDS, PROTO_TCP, other_addr(), tgt_addr, 16'h4321, 16'd22, F_SYN,
                   33, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, tgt_addr, 16'd80, 16'd22,
                   F_SYN | F_ACK, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, tgt_addr, other_addr(), 16'd8080, 16'h1234,
                   8'hFF, 0, 0, 1'b0);
        add_packet(IP_MIN_WORDS, PROTO_TCP, other_addr(), tgt_addr, 16'h4321, 16'd9999,
                   F_SYN, 0, 0, 1'b0);
        add_packet(4'd0, PROTO_TCP, other_addr(), tgt_addr, 16'h4321, 16'd22, F_SYN,
                   1, 0, 1'b0);
        add_packet(4'd0, PROTO_TCP, other_addr(), tgt_addr, 16'h4321, 16'd22, F_SYN,
                   0, 0, 1'b0);

        // random traffic under several targets and idle rates
        begin_phase(32'hFFFF_FFFF, 38);
        make_random_traffic(150, 3);
        begin_phase(32'h0000_0000, 77);
        make_random_traffic(150, 3);
        begin_phase($urandom, 77);
        make_random_traffic(150, 3);
        begin_phase($urandom, 0);
        make_random_traffic(150, 3);

        wait_drained();
        repeat (20) @(negedge clk);
        if (err_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #(4 * 1000000);
        $display("simulation failed");
        $finish;
    end

endmodule

### syn_scan_port_tracker.f
src/sst_pkg.sv
src/sst_front.sv
src/sst_fifo.sv
src/sst_back.sv
src/syn_scan_port_tracker.sv
dv/tb.sv
